// ===== design/rle_pkg.sv =====
// package: shared constants and types for the rgb led effect generator
`default_nettype none
package rle_pkg;

  localparam int LED_COUNT_DEF = 8;
  localparam int STAMP_W = 32;
  localparam int PERIOD_W = 16;
  localparam int MODE_W = 3;
  localparam int PHASE_W = 8;
  localparam int COLOR_W = 8;
  localparam int PIX_W = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [MODE_W-1:0] MODE_OFF     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_STATIC  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FLOWING = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RUNNING = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BREATHE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 1'b1;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd20;

  localparam logic [PHASE_W-1:0] STEP_FLOWING = 8'd3;
  localparam logic [PHASE_W-1:0] STEP_RUNNING = 8'd1;
  localparam logic [PHASE_W-1:0] STEP_BREATHE = 8'd2;

  localparam logic [COLOR_W-1:0] STATIC_R = 8'd80;
  localparam logic [COLOR_W-1:0] STATIC_G = 8'd16;
  localparam logic [COLOR_W-1:0] STATIC_B = 8'd160;
  localparam logic [COLOR_W-1:0] AMBER_R  = 8'd255;
  localparam logic [COLOR_W-1:0] AMBER_G  = 8'd60;
  localparam logic [COLOR_W-1:0] AMBER_B  = 8'd0;
  localparam logic [COLOR_W-1:0] FULL     = 8'd255;
  localparam logic [COLOR_W-1:0] BREATHE_TOP = 8'd127;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [PHASE_W-1:0] phase;
  } rle_frame_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rle_color_t;

endpackage
`default_nettype wire

// ===== design/rle_if.sv =====
// interfaces: timestamp input channel and pixel result channel
`default_nettype none
interface rle_in_if import rle_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAMP_W-1:0] now_ms;

  modport source (output valid, output now_ms, input ready);
  modport sink   (input valid, input now_ms, output ready);
endinterface

interface rle_out_if import rle_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   pixel_index;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic               frame_end;

  modport source (output valid, output pixel_index, output red, output green,
                  output blue, output frame_end, input ready);
  modport sink   (input valid, input pixel_index, input red, input green,
                  input blue, input frame_end, output ready);
endinterface
`default_nettype wire

// ===== design/rgb_led_effect_generator.sv =====
// top level: frame timing, led sequencing and the result register
// flow: a due timestamp waits in the input register and each pixel leaves
//   through the result register, one pixel per cycle from the led counter while
//   the result channel is not stalled; a timestamp that is not due is dropped
// reset: synchronous active low; mode off, period 20 ms, stamp and phase 0
`default_nettype none
module rgb_led_effect_generator import rle_pkg::*; #(
  parameter int LED_COUNT = LED_COUNT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  rle_in_if.sink                     in_ch,
  rle_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LED_COUNT - 1);

  // configuration registers
  logic [MODE_W-1:0]   mode_r;
  logic [PERIOD_W-1:0] period_r;

  // effect state
  logic [STAMP_W-1:0]  stamp_r;
  logic [PHASE_W-1:0]  phase_r;

  // input register: one timestamp waiting to be judged and rendered
  logic                job_v_r;
  logic [STAMP_W-1:0]  job_now_r;
  logic [IDX_W-1:0]    idx_r;

  // result register
  logic                out_v_r;
  logic [PIX_W-1:0]    out_idx_r;
  rle_color_t          out_color_r;
  logic                out_end_r;

  logic [STAMP_W-1:0]  elapsed;
  logic                due;
  logic                out_free;
  logic                emit;
  logic                last;
  logic                job_done;
  logic [PHASE_W-1:0]  step;
  rle_frame_t          frame;
  rle_color_t          pix_color;
  logic [PIX_W-1:0]    pix_idx;

  // frame is due once the wrapped elapsed time reaches the period; stamp and
  // phase only change on the last pixel, so this stays steady over a frame
  assign elapsed  = job_now_r - stamp_r;
  assign due      = elapsed >= STAMP_W'(period_r);
  assign out_free = !out_v_r || out_ch.ready;
  assign emit     = job_v_r && due && out_free;
  assign last     = (idx_r == IDX_LAST);
  // a stale timestamp is dropped without waiting on the result channel; a due one leaves on its last beat
  assign job_done = job_v_r && (!due || (emit && last));

  // the next timestamp can enter while the current one retires
  assign in_ch.ready = !job_v_r || job_done;

  assign frame.mode  = mode_r;
  assign frame.phase = phase_r;

  always_comb begin
    case (mode_r)
      MODE_FLOWING: step = STEP_FLOWING;
      MODE_RUNNING: step = STEP_RUNNING;
      MODE_BREATHE: step = STEP_BREATHE;
      default:      step = '0;
    endcase
  end

  // pixel index wraps to its low bits on long strips
  always_comb begin
    pix_idx = '0;
    pix_idx[IDX_W > PIX_W ? PIX_W-1 : IDX_W-1:0] =
      idx_r[IDX_W > PIX_W ? PIX_W-1 : IDX_W-1:0];
  end

  rle_pixel_gen #(
    .LED_COUNT (LED_COUNT)
  ) u_pixel (
    .frame (frame),
    .idx   (idx_r),
    .color (pix_color)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_OFF;
      period_r <= PERIOD_RESET;
      stamp_r  <= '0;
      phase_r  <= '0;
      job_v_r  <= 1'b0;
      idx_r    <= '0;
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MODE:   mode_r   <= cfg_wdata[MODE_W-1:0];
          REG_PERIOD: period_r <= cfg_wdata[PERIOD_W-1:0];
          default: ;
        endcase
      end

      // end of frame: remember the stamp and advance the animation
      if (emit && last) begin
        stamp_r <= job_now_r;
        phase_r <= phase_r + step;
      end

      if (emit) begin
        idx_r <= last ? '0 : idx_r + 1'b1;
      end

      if (in_ch.valid && in_ch.ready) begin
        job_v_r <= 1'b1;
      end else if (job_done) begin
        job_v_r <= 1'b0;
      end

      if (emit) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      job_now_r <= in_ch.now_ms;
    end
    if (emit) begin
      out_idx_r   <= pix_idx;
      out_color_r <= pix_color;
      out_end_r   <= last;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.pixel_index = out_idx_r;
  assign out_ch.red         = out_color_r.red;
  assign out_ch.green       = out_color_r.green;
  assign out_ch.blue        = out_color_r.blue;
  assign out_ch.frame_end   = out_end_r;

endmodule
`default_nettype wire

// ===== design/rle_pixel_gen.sv =====
// pixel color logic: color of one led from mode, phase and led index
`default_nettype none
module rle_pixel_gen import rle_pkg::*; #(
  parameter int LED_COUNT = LED_COUNT_DEF,
  localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1
) (
  input  rle_frame_t       frame,
  input  logic [IDX_W-1:0] idx,
  output rle_color_t       color
);

  // running dot position is (phase >> 3) mod LED_COUNT; the shifted value
  // is below 32, so match it against every alias idx + k * LED_COUNT
  localparam int SEL_W = PHASE_W - 3;
  localparam int NSEL = 1 << SEL_W;
  localparam int CMP_W = 12;

  logic [SEL_W-1:0]   dot_sel;
  logic               dot_hit;
  logic [COLOR_W-1:0] flow_q;
  logic [5:0]         tri_t;
  logic [COLOR_W-1:0] tri_w;
  logic [2:0]         idx_lo;

  assign dot_sel = frame.phase[PHASE_W-1:3];

  always_comb begin
    dot_hit = 1'b0;
    for (int k = 0; k < NSEL; k++) begin
      if (CMP_W'(idx) + CMP_W'(k * LED_COUNT) == CMP_W'(dot_sel)) begin
        dot_hit = 1'b1;
      end
    end
  end

  // flowing: phase plus 32 per led, wraps at 256
  always_comb begin
    idx_lo = '0;
    idx_lo[IDX_W > 3 ? 2 : IDX_W-1:0] = idx[IDX_W > 3 ? 2 : IDX_W-1:0];
  end
  assign flow_q = frame.phase + {idx_lo, 5'b0};

  // breathe: triangle wave over bit 6 of the phase
  assign tri_t = frame.phase[5:0];
  assign tri_w = frame.phase[6] ? (BREATHE_TOP - {1'b0, tri_t, 1'b0})
                                : {1'b0, tri_t, 1'b0};

  always_comb begin
    color = '0;
    unique case (frame.mode)
      MODE_STATIC: begin
        color.red   = STATIC_R;
        color.green = STATIC_G;
        color.blue  = STATIC_B;
      end
      MODE_FLOWING: begin
        color.red   = flow_q;
        color.green = FULL - flow_q;
        color.blue  = {1'b0, flow_q[COLOR_W-1:1]};
      end
      MODE_RUNNING: begin
        if (dot_hit) begin
          color.red   = AMBER_R;
          color.green = AMBER_G;
          color.blue  = AMBER_B;
        end
      end
      MODE_BREATHE: begin
        color.red   = tri_w;
        color.green = tri_w;
        color.blue  = FULL;
      end
      default: color = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// testbench for the rgb led effect generator: self-checking, random and directed
`timescale 1ns / 1ps
module testbench;
  import rle_pkg::*;

  localparam int LED_N = LED_COUNT_DEF;
  // worst case: 270 frames x 8 pixels, each behind the longest stall, plus input gaps, taken several times
  localparam int CYCLE_LIMIT = 600000;
  // idle time after the last expected pixel
  localparam int DRAIN_CYCLES = LED_N + 8;
  localparam int REPORT_MAX = 10;

  // one expected pixel beat as the result channel carries it
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    rle_color_t       color;
    logic             last;
  } pixel_beat_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rle_in_if  in_ch ();
  rle_out_if out_ch ();

  rgb_led_effect_generator #(
    .LED_COUNT(LED_N)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // shadow copy of the block state used to work out each frame
  logic [MODE_W-1:0]   mode_q;
  logic [PERIOD_W-1:0] period_q;
  logic [STAMP_W-1:0]  frame_stamp_q;
  logic [PHASE_W-1:0]  phase_q;

  pixel_beat_t pending_pixels[$];

  int cycle_count;
  int mismatch_count;
  int stamps_sent;
  int frames_due;
  int pixels_checked;
  int reg_writes;
  bit no_idle;
  int stall_left;

  always #5 clk = ~clk;

  // runaway guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still pending", cycle_count,
               pending_pixels.size());
      $display("rgb_led_effect_generator verification failed");
      $finish;
    end
  end

  // gap length: mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side back-pressure, stalls land on any pixel of a frame
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 99) < 25) begin
      stall_left = pick_gap();
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic note_mismatch(input string field, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("mismatch on %s at cycle %0d: expected %0d, got %0d", field, cycle_count,
               want, got);
  endtask

  // compare every accepted pixel beat with the oldest pending expectation
  always @(posedge clk) begin
    pixel_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected pixel beat at cycle %0d: index %0d rgb %0d,%0d,%0d",
                   cycle_count, out_ch.pixel_index, out_ch.red, out_ch.green, out_ch.blue);
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (out_ch.pixel_index !== want.pix)
          note_mismatch("pixel_index", want.pix, out_ch.pixel_index);
        if (out_ch.red !== want.color.red)
          note_mismatch("red", want.color.red, out_ch.red);
        if (out_ch.green !== want.color.green)
          note_mismatch("green", want.color.green, out_ch.green);
        if (out_ch.blue !== want.color.blue)
          note_mismatch("blue", want.color.blue, out_ch.blue);
        if (out_ch.frame_end !== want.last)
          note_mismatch("frame_end", want.last, out_ch.frame_end);
      end
    end
  end

  // work out the frame one timestamp causes and advance the shadow state
  task automatic predict_frame(input logic [STAMP_W-1:0] stamp);
    logic [STAMP_W-1:0] age;
    logic [PHASE_W-1:0] q;
    logic [PHASE_W-1:0] t;
    logic [COLOR_W-1:0] w;
    int lit;
    pixel_beat_t b;
    age = stamp - frame_stamp_q;
    // wrapping age below the period: not due, nothing comes out
    if (age < {{(STAMP_W-PERIOD_W){1'b0}}, period_q}) return;
    frame_stamp_q = stamp;
    frames_due++;
    lit = (phase_q >> 3) % LED_N;
    t = phase_q & 8'h3F;
    // triangle wave: rising on the first half, falling when bit 6 is set
    w = phase_q[6] ? BREATHE_TOP - COLOR_W'(t * 2) : COLOR_W'(t * 2);
    for (int i = 0; i < LED_N; i++) begin
      b.pix = PIX_W'(i);
      b.last = (i == LED_N - 1);
      case (mode_q)
        MODE_STATIC: b.color = rle_color_t'{STATIC_R, STATIC_G, STATIC_B};
        MODE_FLOWING: begin
          q = phase_q + PHASE_W'(i * 32);
          b.color = rle_color_t'{q, FULL - q, q >> 1};
        end
        MODE_RUNNING: b.color = (i == lit) ? rle_color_t'{AMBER_R, AMBER_G, AMBER_B}
                                           : rle_color_t'('0);
        MODE_BREATHE: b.color = rle_color_t'{w, w, FULL};
        // off and the undefined codes blank the strip
        default: b.color = '0;
      endcase
      pending_pixels.push_back(b);
    end
    case (mode_q)
      MODE_FLOWING: phase_q = phase_q + STEP_FLOWING;
      MODE_RUNNING: phase_q = phase_q + STEP_RUNNING;
      MODE_BREATHE: phase_q = phase_q + STEP_BREATHE;
      default: ;
    endcase
  endtask

  // one timestamp beat; valid stays up after acceptance until the next call or drain
  task automatic send_stamp(input logic [STAMP_W-1:0] stamp);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.now_ms <= stamp;
    do @(posedge clk); while (!in_ch.ready);
    stamps_sent++;
    predict_frame(stamp);
  endtask

  // stop sending and let every pending pixel and any not-due stamp clear the block
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register writes happen only with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    if (idx == REG_MODE) mode_q = data[MODE_W-1:0];
    else period_q = data;
  endtask

  // reset values: off, 20 ms, stamp 0; wrap of the age across 2^32
  task automatic test_reset_timing();
    send_stamp(32'd0);          // age 0, not due
    send_stamp(32'd19);         // one short of the period
    send_stamp(32'd20);         // exactly due
    send_stamp(32'd39);
    send_stamp(32'd40);
    send_stamp(32'hFFFF_FFFF);  // huge forward age
    send_stamp(32'd5);          // wraps to age 6, not due
    send_stamp(32'd19);         // wraps to age 20, due
  endtask

  // every mode code from 1 to 7 with a zero period, so each stamp gives a frame
  task automatic test_all_modes();
    logic [CFG_DATA_W-1:0] data;
    write_reg(REG_PERIOD, 16'd0);
    for (int m = 1; m < 8; m++) begin
      data = CFG_DATA_W'(m);
      // undefined codes also carry junk in the upper bits
      if (m > MODE_BREATHE) data[CFG_DATA_W-1:MODE_W] = (CFG_DATA_W-MODE_W)'($urandom);
      write_reg(REG_MODE, data);
      send_stamp(frame_stamp_q);  // same stamp again still fires
      send_stamp(frame_stamp_q + 32'd1);
    end
  endtask

  // largest and smallest nonzero period around the boundary
  task automatic test_period_edges();
    write_reg(REG_MODE, CFG_DATA_W'(MODE_RUNNING));
    write_reg(REG_PERIOD, 16'hFFFF);
    send_stamp(frame_stamp_q + 32'd65534);
    send_stamp(frame_stamp_q + 32'd65535);
    write_reg(REG_PERIOD, 16'd1);
    send_stamp(frame_stamp_q);
    send_stamp(frame_stamp_q + 32'd1);
  endtask

  // random settings, mostly due stamps with some not due and some arbitrary
  task automatic test_random_stream();
    logic [CFG_DATA_W-1:0] mode_word;
    logic [CFG_DATA_W-1:0] period_word;
    logic [STAMP_W-1:0] delta;
    int r;
    for (int run = 0; run < 10; run++) begin
      r = $urandom_range(0, 9);
      // flowing, running and breathe weighted up so the phase walks far
      if (r < 6) mode_word = CFG_DATA_W'($urandom_range(MODE_FLOWING, MODE_BREATHE));
      else mode_word = CFG_DATA_W'($urandom_range(0, 7));
      if ($urandom_range(0, 3) == 0)
        mode_word[CFG_DATA_W-1:MODE_W] = (CFG_DATA_W-MODE_W)'($urandom);
      case ($urandom_range(0, 5))
        0: period_word = 16'd0;
        1: period_word = 16'd1;
        2: period_word = PERIOD_RESET;
        3: period_word = 16'hFFFF;
        4: period_word = CFG_DATA_W'($urandom_range(2, 100));
        default: period_word = CFG_DATA_W'($urandom);
      endcase
      write_reg(REG_MODE, mode_word);
      write_reg(REG_PERIOD, period_word);
      no_idle = (run % 3 == 0);
      for (int k = 0; k < 24; k++) begin
        r = $urandom_range(0, 99);
        if (r < 70) delta = STAMP_W'(period_q) + $urandom_range(0, 3);
        else if (r < 90) delta = $urandom_range(0, period_q);
        else delta = $urandom;
        send_stamp(frame_stamp_q + delta);
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.now_ms = '0;
    out_ch.ready = 1'b0;
    stall_left = 0;
    no_idle = 1'b0;
    cycle_count = 0;
    mismatch_count = 0;
    stamps_sent = 0;
    frames_due = 0;
    pixels_checked = 0;
    reg_writes = 0;
    mode_q = MODE_OFF;
    period_q = PERIOD_RESET;
    frame_stamp_q = '0;
    phase_q = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_timing();
    test_all_modes();
    test_period_edges();
    test_random_stream();
    drain();

    if (pending_pixels.size() != 0) begin
      mismatch_count++;
      $display("%0d expected pixels never arrived", pending_pixels.size());
    end
    $display("covered %0d timestamps, %0d frames, %0d pixels checked, %0d register writes",
             stamps_sent, frames_due, pixels_checked, reg_writes);
    $display("all mode codes and periods from 0 to 65535 exercised, %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("rgb_led_effect_generator verification clean");
    end else begin
      $display("rgb_led_effect_generator verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/rle_pkg.sv
design/rle_if.sv
design/rle_pixel_gen.sv
design/rgb_led_effect_generator.sv
tb/testbench.sv
